### hdl/plar_pkg.sv
// Shared types and constants for the piecewise-linear alpha ramp.
package plar_pkg;

    // Field widths
    localparam int FRAC_BITS    = 16;
    localparam int PIX_W        = 12;
    localparam int SLOT_W       = 4;
    localparam int COORD_W      = 17;
    localparam int ALPHA_W      = 8;
    localparam int PCNT_W       = 13;
    localparam int NPT_W        = 5;

    // Default table depth
    localparam int MAX_POINTS_DEF = 16;

    // Stream and config port widths
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 24;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = PCNT_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'b1;

    // Shared divider: dividend pixel_index << FRAC_BITS
    localparam int DIV_W        = PIX_W + FRAC_BITS;
    localparam int DCNT_W       = $clog2(DIV_W + 1);

    // Interpolation widths
    localparam int PROD_W       = 2 * COORD_W;
    localparam int NUM_W        = PROD_W + 1;
    localparam int SC_W         = NUM_W + ALPHA_W;
    localparam int NQ_W         = SC_W - FRAC_BITS;
    localparam int DY_W         = COORD_W + ALPHA_W;
    localparam int DH_W         = DY_W - FRAC_BITS;

    // Controller to datapath commands
    typedef struct packed {
        logic wr_point;
        logic start_eval;
        logic div_step;
        logic div_to_alpha;
        logic search;
        logic direct;
        logic mul;
        logic sum;
        logic scale;
        logic a_init;
        logic out_load;
    } plar_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;
        logic hit_direct;
        logic hit_interp;
        logic sat;
        logic out_free;
    } plar_sts_t;

endpackage

### hdl/plar_ctrl.sv
// Sequencing state machine for point writes and pixel evaluation.
module plar_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                func,
    output logic                s_tready,
    output plar_pkg::plar_cmd_t cmd,
    input  plar_pkg::plar_sts_t sts
);
    import plar_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_DIV_X  = 11'b000_0000_0010,
        ST_SEARCH = 11'b000_0000_0100,
        ST_FETCH  = 11'b000_0000_1000,
        ST_DIRECT = 11'b000_0001_0000,
        ST_MUL    = 11'b000_0010_0000,
        ST_SUM    = 11'b000_0100_0000,
        ST_SCALE  = 11'b000_1000_0000,
        ST_A_INIT = 11'b001_0000_0000,
        ST_DIV_A  = 11'b010_0000_0000,
        ST_DONE   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (func)
                    begin
                        cmd.start_eval = 1'b1;
                        state_next     = ST_DIV_X;
                    end
                    else
                    begin
                        cmd.wr_point = 1'b1;
                    end
                end
            end
            ST_DIV_X:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                if (sts.hit_direct)
                    state_next = ST_DIRECT;
                else if (sts.hit_interp)
                    state_next = ST_MUL;
                else
                    state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = ST_SEARCH;
            end
            ST_DIRECT:
            begin
                cmd.direct = 1'b1;
                state_next = ST_DONE;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_A_INIT;
            end
            ST_A_INIT:
            begin
                cmd.a_init = 1'b1;
                if (sts.sat)
                    state_next = ST_DONE;
                else
                    state_next = ST_DIV_A;
            end
            ST_DIV_A:
            begin
                cmd.div_step     = 1'b1;
                cmd.div_to_alpha = 1'b1;
                if (sts.div_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### hdl/plar_dpath.sv
// Datapath: point table, shared divider, segment search, interpolation, output register.
module plar_dpath #(
    parameter int MAX_POINTS = plar_pkg::MAX_POINTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  plar_pkg::plar_cmd_t            cmd,
    output plar_pkg::plar_sts_t            sts,
    input  logic [plar_pkg::SLOT_W-1:0]    point_index,
    input  logic [plar_pkg::COORD_W-1:0]   point_x,
    input  logic [plar_pkg::COORD_W-1:0]   point_y,
    input  logic [plar_pkg::PIX_W-1:0]     pixel_index,
    input  logic                           cfg_valid,
    input  logic [plar_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [plar_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [plar_pkg::ALPHA_W-1:0]   alpha,
    output logic [plar_pkg::PIX_W-1:0]     pixel_out
);
    import plar_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    // Configuration
    logic [PCNT_W-1:0] pixel_count_reg;
    logic [NPT_W-1:0]  point_count_reg;
    logic [PCNT_W-1:0] pc_live;
    logic [CW-1:0]     n_live;

    // Point table
    logic [COORD_W-1:0] mem_x [MAX_POINTS];
    logic [COORD_W-1:0] mem_y [MAX_POINTS];
    logic [COORD_W-1:0] rd_x_reg, rd_y_reg;
    logic               slot_ok;

    // Search
    logic [CW-1:0]      k_reg;
    logic [COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic [COORD_W-1:0] sel_y_reg, yl_reg, yh_reg, d_reg, w_reg, u_reg;
    logic               hit, degen, first_pt, last_pt, advance;
    logic [COORD_W-1:0] sel_y_next;

    // Divider
    logic [COORD_W-1:0] rem_reg, den_reg, rem_step;
    logic [DIV_W-1:0]   quo_reg, quo_step;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [COORD_W:0]   part, diff;
    logic               ge;

    // Interpolation
    logic [PROD_W-1:0]  p0_reg, p1_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [SC_W-1:0]    sc;
    logic [NQ_W-1:0]    nq_reg;
    logic               sat;
    logic [DY_W-1:0]    dy;
    logic [DH_W-1:0]    dh;
    logic [ALPHA_W-1:0] direct_alpha;

    // Result
    logic [PIX_W-1:0]   pix_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic               out_valid_reg;
    logic [ALPHA_W-1:0] out_alpha_reg;
    logic [PIX_W-1:0]   out_pix_reg;

    // Clamped counts
    always_comb
    begin
        pc_live = (pixel_count_reg == '0) ? PCNT_W'(1) : pixel_count_reg;
        if (point_count_reg < NPT_W'(2))
            n_live = CW'(2);
        else if (32'(point_count_reg) > 32'(MAX_POINTS))
            n_live = CW'(MAX_POINTS);
        else
            n_live = CW'(point_count_reg);
    end

    assign slot_ok = (32'(point_index) < 32'(MAX_POINTS));

    // Table write and registered read at the search pointer
    always_ff @(posedge clk)
    begin
        if (cmd.wr_point && slot_ok)
        begin
            mem_x[AW'(point_index)] <= point_x;
            mem_y[AW'(point_index)] <= point_y;
        end
        rd_x_reg <= mem_x[k_reg[AW-1:0]];
        rd_y_reg <= mem_y[k_reg[AW-1:0]];
    end

    // Restoring divider step, one quotient bit per cycle
    always_comb
    begin
        part     = {rem_reg, quo_reg[DIV_W-1]};
        diff     = part - {1'b0, den_reg};
        ge       = (part >= {1'b0, den_reg});
        rem_step = ge ? diff[COORD_W-1:0] : part[COORD_W-1:0];
        quo_step = {quo_reg[DIV_W-2:0], ge};
    end

    // Segment test against the point under the pointer; quo_reg holds x here
    always_comb
    begin
        hit        = (quo_reg <= DIV_W'(rd_x_reg));
        degen      = (rd_x_reg <= prev_x_reg) || (quo_reg <= DIV_W'(prev_x_reg));
        first_pt   = (k_reg == '0);
        last_pt    = (k_reg == n_live - CW'(1));
        sel_y_next = (hit && !first_pt) ? prev_y_reg : rd_y_reg;
    end

    assign sts.hit_direct = (hit && (first_pt || degen)) || (!hit && last_pt);
    assign sts.hit_interp = hit && !first_pt && !degen;
    assign advance        = !sts.hit_direct && !sts.hit_interp;
    assign sts.div_last   = (dcnt_reg == DCNT_W'(1));

    // Scaling: times 255 as times 256 minus one, then drop the fraction
    always_comb
    begin
        sc           = {num_reg, {ALPHA_W{1'b0}}} - SC_W'(num_reg);
        sat          = (nq_reg >= NQ_W'({d_reg, {ALPHA_W{1'b0}}}));
        dy           = {sel_y_reg, {ALPHA_W{1'b0}}} - DY_W'(sel_y_reg);
        dh           = dy[DY_W-1:FRAC_BITS];
        direct_alpha = (dh[DH_W-1:ALPHA_W] != '0) ? '1 : dh[ALPHA_W-1:0];
    end

    assign sts.sat      = sat;
    assign sts.out_free = !out_valid_reg || out_ready;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg <= PCNT_W'(256);
            point_count_reg <= NPT_W'(2);
            k_reg           <= '0;
            dcnt_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_PIXEL_COUNT: pixel_count_reg <= cfg_data;
                    CFG_POINT_COUNT: point_count_reg <= cfg_data[NPT_W-1:0];
                    default:         ;
                endcase
            end
            if (cmd.start_eval)
            begin
                k_reg    <= '0;
                dcnt_reg <= DCNT_W'(DIV_W);
            end
            if (cmd.div_step)
                dcnt_reg <= dcnt_reg - DCNT_W'(1);
            if (cmd.search && advance)
                k_reg <= k_reg + CW'(1);
            if (cmd.a_init && !sat)
                dcnt_reg <= DCNT_W'(ALPHA_W);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start_eval)
        begin
            pix_reg <= pixel_index;
            quo_reg <= {pixel_index, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= COORD_W'(pc_live);
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_step;
            quo_reg <= quo_step;
            if (cmd.div_to_alpha)
                alpha_reg <= quo_step[ALPHA_W-1:0];
        end
        if (cmd.search)
        begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
            sel_y_reg  <= sel_y_next;
            yl_reg     <= prev_y_reg;
            yh_reg     <= rd_y_reg;
            d_reg      <= rd_x_reg - prev_x_reg;
            w_reg      <= rd_x_reg - quo_reg[COORD_W-1:0];
            u_reg      <= quo_reg[COORD_W-1:0] - prev_x_reg;
        end
        if (cmd.direct)
            alpha_reg <= direct_alpha;
        if (cmd.mul)
        begin
            p0_reg <= yl_reg * w_reg;
            p1_reg <= yh_reg * u_reg;
        end
        if (cmd.sum)
            num_reg <= NUM_W'(p0_reg) + NUM_W'(p1_reg);
        if (cmd.scale)
            nq_reg <= sc[SC_W-1:FRAC_BITS];
        if (cmd.a_init)
        begin
            if (sat)
            begin
                alpha_reg <= '1;
            end
            else
            begin
                rem_reg <= COORD_W'(nq_reg >> ALPHA_W);
                quo_reg <= {nq_reg[ALPHA_W-1:0], {(DIV_W-ALPHA_W){1'b0}}};
                den_reg <= d_reg;
            end
        end
        if (cmd.out_load)
        begin
            out_alpha_reg <= alpha_reg;
            out_pix_reg   <= pix_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign alpha     = out_alpha_reg;
    assign pixel_out = out_pix_reg;

endmodule

### hdl/piecewise_linear_alpha_ramp_core.sv
// A point write is taken in idle. An evaluate item runs the 28-step position divider, then
// walks the table one point per search and fetch pair until the pixel resolves directly at
// point j or interpolates into the segment ending at point j. Interpolation multiplies, sums
// and scales, then divides by the segment width for alpha unless the value saturates.
// One item is worked at a time; a finished result waits in the output register meanwhile.
// Reset clears control state and sets pixel_count to 256, point_count to 2; points are unset.
module piecewise_linear_alpha_ramp_core #(
    parameter int MAX_POINTS = plar_pkg::MAX_POINTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // point_index[3:0], point_x[20:4], point_y[37:21], pixel_index[49:38], zero pad
    input  logic [plar_pkg::IN_TDATA_W-1:0] s_tdata,
    // func[0]
    input  logic                            s_tuser,
    // Result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // alpha[7:0], pixel_out[19:8], zero pad
    output logic [plar_pkg::OUT_TDATA_W-1:0] m_tdata,
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [plar_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [plar_pkg::CFG_DATA_W-1:0] cfg_data
);
    import plar_pkg::*;

    localparam int PX_LSB  = SLOT_W;
    localparam int PY_LSB  = PX_LSB + COORD_W;
    localparam int PIX_LSB = PY_LSB + COORD_W;
    localparam int OUT_USED = ALPHA_W + PIX_W;

    plar_cmd_t          cmd;
    plar_sts_t          sts;
    logic [ALPHA_W-1:0] alpha;
    logic [PIX_W-1:0]   pixel_out;

    assign cfg_ready = 1'b1;

    plar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .func     (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    plar_dpath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .point_index (s_tdata[SLOT_W-1:0]),
        .point_x     (s_tdata[PY_LSB-1:PX_LSB]),
        .point_y     (s_tdata[PIX_LSB-1:PY_LSB]),
        .pixel_index (s_tdata[PIX_LSB+PIX_W-1:PIX_LSB]),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .alpha       (alpha),
        .pixel_out   (pixel_out)
    );

    // Pack result fields, alpha lowest
    assign m_tdata = {{(OUT_TDATA_W-OUT_USED){1'b0}}, pixel_out, alpha};

endmodule
